// File: rtl/tpid_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the turn controller with time limit.
// Used by tpid_csr, tpid_drive and turn_pid_with_timeout.
package tpid_pkg;

   localparam int TICK_PERIOD_MS = 20;

   localparam int OP_W      = 1;
   localparam int ANGLE_W   = 12;
   localparam int DUR_W     = 16;
   localparam int GYRO_W    = 20;
   localparam int GAIN_W    = 16;
   localparam int POWER_W   = 16;
   localparam int TIME_W    = 17;
   localparam int ERR_W     = 21;
   localparam int DIFF_W    = 22;
   localparam int SUM_W     = 32;
   localparam int FRAC_W    = 16;
   localparam int PROP_W    = ERR_W + GAIN_W;
   localparam int INTEG_W   = SUM_W + GAIN_W;
   localparam int DERIV_W   = DIFF_W + GAIN_W;
   localparam int ACC_W     = INTEG_W + 2;
   localparam int SHIFT_W   = ACC_W - FRAC_W;

   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 40;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic signed [POWER_W-1:0] POWER_MAX = 16'sd32767;
   localparam logic signed [SUM_W-1:0]   SUM_MAX   = 32'sh7FFF_FFFF;
   localparam logic signed [SUM_W-1:0]   SUM_MIN   = 32'sh8000_0000;

   typedef enum logic [OP_W-1:0] {
      OP_START = 1'b0,
      OP_TICK  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      REG_PROP_GAIN  = 2'd0,
      REG_INTEG_GAIN = 2'd1,
      REG_DERIV_GAIN = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic signed [GAIN_W-1:0] prop;
      logic signed [GAIN_W-1:0] integ;
      logic signed [GAIN_W-1:0] deriv;
   } gains_type;

   typedef struct packed {
      logic active;
      logic clockwise;
      logic running;
      logic finished;
   } flags_type;

   typedef struct packed {
      flags_type                flags;
      logic signed [ERR_W-1:0]  error;
      logic signed [SUM_W-1:0]  error_sum;
      logic signed [DIFF_W-1:0] error_diff;
   } term_type;

endpackage

// File: rtl/tpid_csr.sv
`timescale 1ns / 1ps
// Gain register file behind the APB-style configuration port.
// Depends on tpid_pkg.
module tpid_csr
   import tpid_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output gains_type             gains
);

   gains_type     gains_ff;
   gains_type     gains_in;
   reg_index_type index;
   logic          write_en;

   assign csr_pready = 1'b1;
   assign index      = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign write_en   = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign gains      = gains_ff;

   always_comb begin
      gains_in = gains_ff;
      if (write_en) begin
         case (index)
            REG_PROP_GAIN:  gains_in.prop  = signed'(csr_pwdata[GAIN_W-1:0]);
            REG_INTEG_GAIN: gains_in.integ = signed'(csr_pwdata[GAIN_W-1:0]);
            REG_DERIV_GAIN: gains_in.deriv = signed'(csr_pwdata[GAIN_W-1:0]);
            default:        gains_in = gains_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_PROP_GAIN:  csr_prdata = CSR_DATA_W'(gains_ff.prop);
         REG_INTEG_GAIN: csr_prdata = CSR_DATA_W'(gains_ff.integ);
         REG_DERIV_GAIN: csr_prdata = CSR_DATA_W'(gains_ff.deriv);
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff <= '0;
      end else begin
         gains_ff <= gains_in;
      end
   end

endmodule

// File: rtl/tpid_drive.sv
`timescale 1ns / 1ps
// Product stage and sum/saturate/output stage of the drive computation.
// Depends on tpid_pkg.
module tpid_drive
   import tpid_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  gains_type             gains,
   input  logic                  term_valid,
   input  term_type              term,
   output logic                  term_ready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // {6'b0, finished, running, right_power[15:0], left_power[15:0]}
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic                       prod_valid_ff;
   logic                       prod_valid_in;
   flags_type                  prod_flags_ff;
   logic signed [PROP_W-1:0]   prod_prop_ff;
   logic signed [PROP_W-1:0]   prod_prop_in;
   logic signed [INTEG_W-1:0]  prod_integ_ff;
   logic signed [INTEG_W-1:0]  prod_integ_in;
   logic signed [DERIV_W-1:0]  prod_deriv_ff;
   logic signed [DERIV_W-1:0]  prod_deriv_in;

   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic [RSP_DATA_W-1:0]      rsp_data_ff;
   logic [RSP_DATA_W-1:0]      rsp_data_in;

   logic                       out_ready;
   logic                       prod_ready;
   logic signed [ACC_W-1:0]    acc;
   logic signed [SHIFT_W-1:0]  shifted;
   logic signed [POWER_W-1:0]  power;
   logic signed [POWER_W-1:0]  left_power;
   logic signed [POWER_W-1:0]  right_power;

   assign out_ready  = ~rsp_valid_ff | rsp_tready;
   assign prod_ready = ~prod_valid_ff | out_ready;
   assign term_ready = prod_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign prod_valid_in = prod_ready ? term_valid : prod_valid_ff;
   assign prod_prop_in  = term.error * gains.prop;
   assign prod_integ_in = term.error_sum * gains.integ;
   assign prod_deriv_in = term.error_diff * gains.deriv;

   always_comb begin
      acc = ACC_W'(prod_prop_ff) + ACC_W'(prod_integ_ff) + ACC_W'(prod_deriv_ff);
      shifted = SHIFT_W'(acc >>> FRAC_W);
      if (shifted > SHIFT_W'(POWER_MAX)) begin
         power = POWER_MAX;
      end else if (shifted < -SHIFT_W'(POWER_MAX)) begin
         power = -POWER_MAX;
      end else begin
         power = POWER_W'(shifted);
      end
      if (!prod_flags_ff.active) begin
         left_power  = '0;
         right_power = '0;
      end else if (prod_flags_ff.clockwise) begin
         left_power  = power;
         right_power = -power;
      end else begin
         left_power  = -power;
         right_power = power;
      end
      rsp_data_in = {6'b0, prod_flags_ff.finished, prod_flags_ff.running,
                     right_power, left_power};
   end

   assign rsp_valid_in = out_ready ? prod_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (term_valid && prod_ready) begin
         prod_flags_ff <= term.flags;
         prod_prop_ff  <= prod_prop_in;
         prod_integ_ff <= prod_integ_in;
         prod_deriv_ff <= prod_deriv_in;
      end
      if (prod_valid_ff && out_ready) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// File: rtl/turn_pid_with_timeout.sv
`timescale 1ns / 1ps
// Turn controller with time limit: PID drive from gyro angle, top level.
// An accepted beat passes the input, term, product and output registers in turn.
// Throughput: one beat per cycle; input, term, product and output registers
// each hold one beat and advance independently, so stalls only back up.
// Reset clears gains, timer, errors and the stored move; the block is idle.
// Depends on tpid_pkg, tpid_csr and tpid_drive.
module turn_pid_with_timeout
   import tpid_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // {gyro_angle[48:29], duration_ms[28:13], clockwise[12], target_angle[11:0]}
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // op
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // {6'b0, finished, running, right_power[15:0], left_power[15:0]}
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   gains_type                  gains;

   logic                       in_valid_ff;
   op_type                     in_op_ff;
   logic signed [ANGLE_W-1:0]  in_target_ff;
   logic                       in_clockwise_ff;
   logic [DUR_W-1:0]           in_duration_ff;
   logic signed [GYRO_W-1:0]   in_gyro_ff;

   logic                       term_valid_ff;
   logic                       term_valid_in;
   term_type                   term_ff;
   term_type                   term_in;
   logic                       drive_ready;
   logic                       term_ready;
   logic                       term_load;

   logic [TIME_W-1:0]          elapsed_ff;
   logic [TIME_W-1:0]          elapsed_in;
   logic signed [ERR_W-1:0]    prev_error_ff;
   logic signed [ERR_W-1:0]    prev_error_in;
   logic signed [SUM_W-1:0]    error_sum_ff;
   logic signed [SUM_W-1:0]    error_sum_in;
   logic signed [ANGLE_W-1:0]  target_ff;
   logic signed [ANGLE_W-1:0]  target_in;
   logic                       direction_ff;
   logic                       direction_in;
   logic [DUR_W-1:0]           limit_ff;
   logic [DUR_W-1:0]           limit_in;

   logic signed [ERR_W-1:0]    error;
   logic signed [DIFF_W-1:0]   error_diff;
   logic signed [SUM_W:0]      sum_wide;
   logic signed [SUM_W-1:0]    sum_sat;
   logic [TIME_W-1:0]          elapsed_next;
   logic                       active;

   tpid_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .gains       (gains)
   );

   tpid_drive u_drive (
      .clock      (clock),
      .reset      (reset),
      .gains      (gains),
      .term_valid (term_valid_ff),
      .term       (term_ff),
      .term_ready (drive_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   assign term_ready    = ~term_valid_ff | drive_ready;
   assign req_tready    = ~in_valid_ff | term_ready;
   assign term_load     = in_valid_ff & term_ready;
   assign term_valid_in = term_ready ? in_valid_ff : term_valid_ff;

   always_comb begin
      error = ERR_W'(signed'({target_ff, 4'b0000})) - ERR_W'(in_gyro_ff);
      error_diff = DIFF_W'(error) - DIFF_W'(prev_error_ff);
      sum_wide = (SUM_W + 1)'(error_sum_ff) + (SUM_W + 1)'(error);
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
         sum_sat = sum_wide[SUM_W-1:0];
      end
      elapsed_next = elapsed_ff + TIME_W'(TICK_PERIOD_MS);
      active = elapsed_ff < TIME_W'(limit_ff);
   end

   always_comb begin
      elapsed_in    = elapsed_ff;
      prev_error_in = prev_error_ff;
      error_sum_in  = error_sum_ff;
      target_in     = target_ff;
      direction_in  = direction_ff;
      limit_in      = limit_ff;
      term_in       = '0;
      term_in.error      = error;
      term_in.error_sum  = sum_sat;
      term_in.error_diff = error_diff;
      if (in_op_ff == OP_START) begin
         target_in     = in_target_ff;
         direction_in  = in_clockwise_ff;
         limit_in      = in_duration_ff;
         elapsed_in    = '0;
         prev_error_in = '0;
         error_sum_in  = '0;
         term_in.flags.running = (in_duration_ff != '0);
      end else if (active) begin
         prev_error_in = error;
         error_sum_in  = sum_sat;
         elapsed_in    = elapsed_next;
         term_in.flags.active    = 1'b1;
         term_in.flags.clockwise = direction_ff;
         term_in.flags.running   = 1'b1;
         term_in.flags.finished  = elapsed_next >= TIME_W'(limit_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         term_valid_ff <= 1'b0;
         elapsed_ff    <= '0;
         prev_error_ff <= '0;
         error_sum_ff  <= '0;
         target_ff     <= '0;
         direction_ff  <= 1'b0;
         limit_ff      <= '0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         term_valid_ff <= term_valid_in;
         if (term_load) begin
            elapsed_ff    <= elapsed_in;
            prev_error_ff <= prev_error_in;
            error_sum_ff  <= error_sum_in;
            target_ff     <= target_in;
            direction_ff  <= direction_in;
            limit_ff      <= limit_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_op_ff        <= op_type'(req_tuser);
         in_target_ff    <= signed'(req_tdata[11:0]);
         in_clockwise_ff <= req_tdata[12];
         in_duration_ff  <= req_tdata[28:13];
         in_gyro_ff      <= signed'(req_tdata[48:29]);
      end
      if (term_load) begin
         term_ff <= term_in;
      end
   end

endmodule
